// File: hdl/slru_pkg.sv
// Shared types and constants for the set-associative LRU tag directory.
// No dependencies; imported by the controller, the datapath and the top level.
package slru_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int SET_OUT_W  = 6;
    localparam int CNT_W      = 32;
    localparam int SET_LUT_N  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [2:0] FIELD_LIMIT        = 3'd6;
    localparam logic [2:0] OFFSET_BITS_RESET  = 3'd3;
    localparam logic [2:0] INDEX_BITS_RESET   = 3'd6;
    localparam logic [3:0] WAYS_IN_USE_RESET  = 4'd8;

    typedef struct packed {
        logic clear;
        logic accept;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
    } status_t;

endpackage

// File: hdl/slru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-set rows of the tag directory.
module slru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/slru_ctrl.sv
// Controller state machine: clearing sweep, idle and lookup states.
// Depends on slru_pkg for the command and status structs.
module slru_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  slru_pkg::status_t status,
    output slru_pkg::cmd_t   cmd,
    output logic             busy
);

    import slru_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.accept = start && (state_reg == ST_IDLE);
    assign cmd.update = (state_reg == ST_LOOKUP);

    a_lookup_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.update)
        else $error("lookup did not follow an accepted item");

    a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> !busy)
        else $error("lookup held longer than one cycle");

    a_no_accept_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !cmd.accept)
        else $error("item accepted during clearing sweep");

endmodule

// File: hdl/slru_dpath.sv
// Datapath: config registers, address split, set-row RAM, hit/victim logic,
// LRU rank update, counters and result registers. Depends on slru_pkg, slru_ram.
module slru_dpath #(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 64,
    parameter int ADDR_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [slru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [ADDR_BITS-1:0]              address,
    input  slru_pkg::cmd_t                    cmd,
    output slru_pkg::status_t                 status,
    output logic                              done,
    output logic                              hit,
    output logic [slru_pkg::SET_OUT_W-1:0]    set_index,
    output logic [ADDR_BITS-1:0]              tag_value,
    output logic                              replaced_valid,
    output logic [slru_pkg::CNT_W-1:0]        access_total,
    output logic [slru_pkg::CNT_W-1:0]        miss_total
);

    import slru_pkg::*;

    localparam int SW      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENTRY_W = 1 + RW + ADDR_BITS;
    localparam int ROW_W   = MAX_WAYS * ENTRY_W;
    localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);
    localparam logic [4:0]    WAYS_MAX = 5'(MAX_WAYS);

    logic [2:0]           offset_bits_reg;
    logic [2:0]           index_bits_reg;
    logic [3:0]           ways_reg;
    logic [SW-1:0]        sweep_reg;
    logic [SW-1:0]        set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [CNT_W-1:0]     access_reg;
    logic [CNT_W-1:0]     miss_reg;
    logic                 done_reg;
    logic                 hit_reg;
    logic                 replaced_reg;
    logic [SW-1:0]        set_out_reg;
    logic [ADDR_BITS-1:0] tag_out_reg;

    logic [2:0]           ob;
    logic [2:0]           ib;
    logic [3:0]           shamt;
    logic [5:0]           set_mask;
    logic [5:0]           set_raw;
    logic [SW-1:0]        set_c;
    logic [ADDR_BITS-1:0] tag_c;
    logic [SW-1:0]        set_lut [SET_LUT_N];
    logic [4:0]           nways;

    logic [ROW_W-1:0]     row_rd;
    logic [ROW_W-1:0]     row_upd;
    logic [ROW_W-1:0]     row_clr;
    logic [ROW_W-1:0]     row_wr;
    logic [SW-1:0]        waddr;
    logic                 we;

    logic                 hit_c;
    logic                 free_c;
    logic                 evict_c;
    logic [RW-1:0]        pick_c;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RESET;
            index_bits_reg  <= INDEX_BITS_RESET;
            ways_reg        <= WAYS_IN_USE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[2:0];
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[2:0];
                CFG_WAYS_IN_USE: ways_reg        <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Address split
    assign ob       = (offset_bits_reg > FIELD_LIMIT) ? FIELD_LIMIT : offset_bits_reg;
    assign ib       = (index_bits_reg > FIELD_LIMIT) ? FIELD_LIMIT : index_bits_reg;
    assign shamt    = {1'b0, ob} + {1'b0, ib};
    assign set_mask = 6'((7'd1 << ib) - 7'd1);
    assign set_raw  = 6'(address >> ob) & set_mask;
    assign tag_c    = address >> shamt;

    for (genvar i = 0; i < SET_LUT_N; i++)
    begin : g_set_lut
        assign set_lut[i] = SW'(i % MAX_SETS);
    end

    assign set_c = set_lut[set_raw];

    always_comb
    begin
        if (ways_reg == 4'd0)
        begin
            nways = 5'd1;
        end
        else if ({1'b0, ways_reg} > WAYS_MAX)
        begin
            nways = WAYS_MAX;
        end
        else
        begin
            nways = {1'b0, ways_reg};
        end
    end

    // Clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.clear)
        begin
            sweep_reg <= sweep_reg + SW'(1);
        end
    end

    assign status.sweep_last = (sweep_reg == SW'(MAX_SETS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg <= set_c;
            tag_reg <= tag_c;
        end
    end

    always_comb
    begin
        row_clr = '0;
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            row_clr[k*ENTRY_W + ADDR_BITS +: RW] = RW'(k);
        end
    end

    // Hit detection, victim choice and rank promotion
    always_comb
    begin
        logic [RW-1:0] oldest;
        logic [RW-1:0] prank;
        logic [RW-1:0] rk;
        logic          vk;
        logic          act;
        hit_c   = 1'b0;
        free_c  = 1'b0;
        evict_c = 1'b0;
        pick_c  = '0;
        oldest  = '0;
        for (int k = MAX_WAYS - 1; k >= 0; k--)
        begin
            vk  = row_rd[k*ENTRY_W + ADDR_BITS + RW];
            act = (5'(k) < nways);
            if (act && vk && (row_rd[k*ENTRY_W +: ADDR_BITS] == tag_reg))
            begin
                hit_c  = 1'b1;
                pick_c = RW'(k);
            end
        end
        if (!hit_c)
        begin
            for (int k = MAX_WAYS - 1; k >= 0; k--)
            begin
                vk  = row_rd[k*ENTRY_W + ADDR_BITS + RW];
                act = (5'(k) < nways);
                if (act && !vk)
                begin
                    free_c = 1'b1;
                    pick_c = RW'(k);
                end
            end
            if (!free_c)
            begin
                evict_c = 1'b1;
                for (int k = 0; k < MAX_WAYS; k++)
                begin
                    rk  = row_rd[k*ENTRY_W + ADDR_BITS +: RW];
                    act = (5'(k) < nways);
                    if (act && ((k == 0) || (rk > oldest)))
                    begin
                        oldest = rk;
                        pick_c = RW'(k);
                    end
                end
            end
        end
        prank   = row_rd[int'(pick_c)*ENTRY_W + ADDR_BITS +: RW];
        row_upd = row_rd;
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            rk  = row_rd[k*ENTRY_W + ADDR_BITS +: RW];
            act = (5'(k) < nways);
            if (RW'(k) == pick_c)
            begin
                row_upd[k*ENTRY_W + ADDR_BITS + RW] = 1'b1;
                row_upd[k*ENTRY_W + ADDR_BITS +: RW] = '0;
                if (!hit_c)
                begin
                    row_upd[k*ENTRY_W +: ADDR_BITS] = tag_reg;
                end
            end
            else if (act && (rk < prank) && (rk < RANK_MAX))
            begin
                row_upd[k*ENTRY_W + ADDR_BITS +: RW] = rk + RW'(1);
            end
        end
    end

    assign we     = cmd.clear || cmd.update;
    assign waddr  = cmd.clear ? sweep_reg : set_reg;
    assign row_wr = cmd.clear ? row_clr : row_upd;

    slru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (row_wr),
        .re    (cmd.accept),
        .raddr (set_c),
        .rdata (row_rd)
    );

    // Counters and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_reg <= '0;
            miss_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.update)
            begin
                access_reg <= access_reg + CNT_W'(1);
                if (!hit_c)
                begin
                    miss_reg <= miss_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg      <= hit_c;
            replaced_reg <= evict_c;
            set_out_reg  <= set_reg;
            tag_out_reg  <= tag_reg;
        end
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign set_index      = SET_OUT_W'(set_out_reg);
    assign tag_value      = tag_out_reg;
    assign replaced_valid = replaced_reg;
    assign access_total   = access_reg;
    assign miss_total     = miss_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.update))
        else $error("result strobe without a lookup");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(hit_reg && replaced_reg))
        else $error("hit reported together with an eviction");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !hit_c) |=> (miss_reg == $past(miss_reg) + CNT_W'(1)))
        else $error("miss counter did not advance on a miss");

endmodule

// File: hdl/set_associative_lru_lookup_top.sv
// Tag directory of a set-associative cache with true LRU replacement.
// Depends on slru_pkg, slru_ctrl, slru_dpath (which holds slru_ram).
//
// Each item is a byte address; it is taken at a clock edge with start high
// and busy low, and its result shows on the result ports in the cycle after
// the lookup cycle, for exactly one cycle with done high. Each item reads the
// set's row of tags, valid bits and ranks from the row RAM as it is taken;
// in the lookup cycle the block compares, picks the hit or victim way and
// writes the updated row back. Busy is high for that one lookup cycle, so no
// new item is taken while the last one is in its lookup. After reset the
// block sweeps every set of the row RAM to clear valid bits and restore
// ranks, with busy high; configuration writes are taken at any time.
module set_associative_lru_lookup_top #(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 64,
    parameter int ADDR_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [slru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [ADDR_BITS-1:0]              address,
    output logic                              done,
    output logic                              hit,
    output logic [slru_pkg::SET_OUT_W-1:0]    set_index,
    output logic [ADDR_BITS-1:0]              tag_value,
    output logic                              replaced_valid,
    output logic [slru_pkg::CNT_W-1:0]        access_total,
    output logic [slru_pkg::CNT_W-1:0]        miss_total
);

    import slru_pkg::*;

    cmd_t    cmd;
    status_t status;

    slru_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    slru_dpath #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .address        (address),
        .cmd            (cmd),
        .status         (status),
        .done           (done),
        .hit            (hit),
        .set_index      (set_index),
        .tag_value      (tag_value),
        .replaced_valid (replaced_valid),
        .access_total   (access_total),
        .miss_total     (miss_total)
    );

endmodule

// File: tb/slru_lookup_checker.sv
// Checker for the set-associative LRU tag directory: tracks register writes,
// predicts every lookup and compares each result strobe. Depends on slru_pkg.
module slru_lookup_checker #(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 64,
    parameter int ADDR_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [slru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    input  logic                              busy,
    input  logic [ADDR_BITS-1:0]              address,
    input  logic                              done,
    input  logic                              hit,
    input  logic [slru_pkg::SET_OUT_W-1:0]    set_index,
    input  logic [ADDR_BITS-1:0]              tag_value,
    input  logic                              replaced_valid,
    input  logic [slru_pkg::CNT_W-1:0]        access_total,
    input  logic [slru_pkg::CNT_W-1:0]        miss_total,
    output int                                errors,
    output int                                pending,
    output int                                lookups,
    output int                                hits,
    output int                                evictions
);
    import slru_pkg::*;

    localparam int RANK_W = $clog2(MAX_WAYS);

    typedef struct packed {
        logic                 hit;
        logic [SET_OUT_W-1:0] set_index;
        logic [ADDR_BITS-1:0] tag_value;
        logic                 replaced_valid;
        logic [CNT_W-1:0]     access_total;
        logic [CNT_W-1:0]     miss_total;
    } lookup_result_t;

    logic [2:0]           offset_sel;
    logic [2:0]           index_sel;
    logic [3:0]           ways_sel;
    logic                 line_valid [MAX_SETS][MAX_WAYS];
    logic [ADDR_BITS-1:0] line_tag   [MAX_SETS][MAX_WAYS];
    logic [RANK_W-1:0]    line_rank  [MAX_SETS][MAX_WAYS];
    logic [CNT_W-1:0]     access_tally;
    logic [CNT_W-1:0]     miss_tally;
    lookup_result_t       results_due[$];

    task automatic clear_directory;
        begin
            offset_sel   = OFFSET_BITS_RESET;
            index_sel    = INDEX_BITS_RESET;
            ways_sel     = WAYS_IN_USE_RESET;
            access_tally = '0;
            miss_tally   = '0;
            for (int s = 0; s < MAX_SETS; s++)
            begin
                for (int w = 0; w < MAX_WAYS; w++)
                begin
                    line_valid[s][w] = 1'b0;
                    line_tag[s][w]   = '0;
                    line_rank[s][w]  = RANK_W'(w);
                end
            end
            results_due.delete();
        end
    endtask

    task automatic predict_lookup(input logic [ADDR_BITS-1:0] addr);
        int                   ob;
        int                   ib;
        int                   nways;
        int                   set_n;
        int                   pick;
        logic [ADDR_BITS-1:0] tag;
        logic [RANK_W-1:0]    oldest;
        logic [RANK_W-1:0]    pick_rank;
        logic                 is_hit;
        logic                 found;
        logic                 evicted;
        lookup_result_t       r;
        begin
            ob = (offset_sel > FIELD_LIMIT) ? int'(FIELD_LIMIT) : int'(offset_sel);
            ib = (index_sel > FIELD_LIMIT) ? int'(FIELD_LIMIT) : int'(index_sel);
            if (ways_sel == 0)
                nways = 1;
            else if (ways_sel > MAX_WAYS)
                nways = MAX_WAYS;
            else
                nways = int'(ways_sel);
            set_n   = int'((addr >> ob) & ((ADDR_BITS'(1) << ib) - ADDR_BITS'(1)));
            set_n   = set_n % MAX_SETS;
            tag     = addr >> (ob + ib);
            is_hit  = 1'b0;
            found   = 1'b0;
            evicted = 1'b0;
            pick    = 0;
            for (int k = 0; k < nways; k++)
            begin
                if (!is_hit && line_valid[set_n][k] && line_tag[set_n][k] == tag)
                begin
                    is_hit = 1'b1;
                    pick   = k;
                end
            end
            if (!is_hit)
            begin
                for (int k = 0; k < nways; k++)
                begin
                    if (!found && !line_valid[set_n][k])
                    begin
                        found = 1'b1;
                        pick  = k;
                    end
                end
                if (!found)
                begin
                    oldest = line_rank[set_n][0];
                    pick   = 0;
                    for (int k = 1; k < nways; k++)
                    begin
                        if (line_rank[set_n][k] > oldest)
                        begin
                            oldest = line_rank[set_n][k];
                            pick   = k;
                        end
                    end
                    evicted = 1'b1;
                end
                line_valid[set_n][pick] = 1'b1;
                line_tag[set_n][pick]   = tag;
                miss_tally              = miss_tally + CNT_W'(1);
            end
            // age the ways that were more recent than the touched way
            pick_rank = line_rank[set_n][pick];
            for (int k = 0; k < nways; k++)
            begin
                if (k != pick && line_rank[set_n][k] < pick_rank &&
                    line_rank[set_n][k] < RANK_W'(MAX_WAYS - 1))
                    line_rank[set_n][k] = line_rank[set_n][k] + RANK_W'(1);
            end
            line_rank[set_n][pick] = '0;
            access_tally = access_tally + CNT_W'(1);

            r.hit            = is_hit;
            r.set_index      = SET_OUT_W'(set_n);
            r.tag_value      = tag;
            r.replaced_valid = evicted;
            r.access_total   = access_tally;
            r.miss_total     = miss_tally;
            results_due.push_back(r);
        end
    endtask

    task automatic check_result;
        lookup_result_t want;
        begin
            if (results_due.size() == 0)
            begin
                $error("result strobe with no lookup pending");
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit);
                    errors++;
                end
                if (set_index !== want.set_index)
                begin
                    $error("set_index: expected %0d, actual %0d", want.set_index, set_index);
                    errors++;
                end
                if (tag_value !== want.tag_value)
                begin
                    $error("tag_value: expected %h, actual %h", want.tag_value, tag_value);
                    errors++;
                end
                if (replaced_valid !== want.replaced_valid)
                begin
                    $error("replaced_valid: expected %0d, actual %0d",
                           want.replaced_valid, replaced_valid);
                    errors++;
                end
                if (access_total !== want.access_total)
                begin
                    $error("access_total: expected %0d, actual %0d",
                           want.access_total, access_total);
                    errors++;
                end
                if (miss_total !== want.miss_total)
                begin
                    $error("miss_total: expected %0d, actual %0d", want.miss_total, miss_total);
                    errors++;
                end
                if (want.hit)
                    hits++;
                if (want.replaced_valid)
                    evictions++;
            end
        end
    endtask

    initial
    begin
        errors    = 0;
        lookups   = 0;
        hits      = 0;
        evictions = 0;
        pending   = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_directory();
            pending <= 0;
        end
        else
        begin
            if (done)
                check_result();
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_OFFSET_BITS: offset_sel = cfg_data[2:0];
                    CFG_INDEX_BITS:  index_sel  = cfg_data[2:0];
                    CFG_WAYS_IN_USE: ways_sel   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                predict_lookup(address);
                lookups++;
            end
            pending <= results_due.size();
        end
    end

endmodule

// File: tb/set_associative_lru_lookup_top_tb.sv
// Testbench top for the set-associative LRU tag directory: drives lookups and
// register writes, runs a watchdog and reports. Depends on slru_pkg, the block
// and slru_lookup_checker.
module set_associative_lru_lookup_top_tb;
    import slru_pkg::*;

    localparam int MAX_WAYS       = 8;
    localparam int MAX_SETS       = 64;
    localparam int ADDR_BITS      = 48;
    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    start;
    logic                    busy;
    logic [ADDR_BITS-1:0]    address;
    logic                    done;
    logic                    hit;
    logic [SET_OUT_W-1:0]    set_index;
    logic [ADDR_BITS-1:0]    tag_value;
    logic                    replaced_valid;
    logic [CNT_W-1:0]        access_total;
    logic [CNT_W-1:0]        miss_total;

    int                      errors;
    int                      pending;
    int                      lookups;
    int                      hits;
    int                      evictions;
    int                      stall_cycles;
    logic [ADDR_BITS-1:0]    tag_pool [12];

    set_associative_lru_lookup_top #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .address        (address),
        .done           (done),
        .hit            (hit),
        .set_index      (set_index),
        .tag_value      (tag_value),
        .replaced_valid (replaced_valid),
        .access_total   (access_total),
        .miss_total     (miss_total)
    );

    slru_lookup_checker #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .address        (address),
        .done           (done),
        .hit            (hit),
        .set_index      (set_index),
        .tag_value      (tag_value),
        .replaced_valid (replaced_valid),
        .access_total   (access_total),
        .miss_total     (miss_total),
        .errors         (errors),
        .pending        (pending),
        .lookups        (lookups),
        .hits           (hits),
        .evictions      (evictions)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_lookup(input logic [ADDR_BITS-1:0] addr, input int idle_pct);
        begin
            while ($urandom_range(1, 100) <= idle_pct)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
            @(negedge clk);
            start   <= 1'b1;
            address <= addr;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic drain_lookups;
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (2) @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
    endtask

    // mostly reuse a few sets and tags so hits and evictions are frequent
    function automatic logic [ADDR_BITS-1:0] stream_address(input int ob, input int ib,
                                                            input int nw);
        logic [63:0]          rnd;
        logic [ADDR_BITS-1:0] tagv;
        logic [ADDR_BITS-1:0] setv;
        logic [ADDR_BITS-1:0] offv;
        int                   nsets;
        int                   near_sets;
        begin
            rnd = {$urandom(), $urandom()};
            if ($urandom_range(1, 100) <= 15)
                return rnd[ADDR_BITS-1:0];
            nsets     = 1 << ib;
            near_sets = (nsets > 4) ? 4 : nsets;
            if ($urandom_range(1, 4) == 1)
                setv = ADDR_BITS'($urandom_range(0, nsets - 1));
            else
                setv = ADDR_BITS'($urandom_range(0, near_sets - 1));
            tagv = tag_pool[$urandom_range(0, nw + 3)];
            offv = rnd[ADDR_BITS-1:0] & ((ADDR_BITS'(1) << ob) - ADDR_BITS'(1));
            return (tagv << (ob + ib)) | (setv << ob) | offv;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("set_associative_lru_lookup_top_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] phase_offset [NUM_PHASES];
        logic [CFG_DATA_W-1:0] phase_index  [NUM_PHASES];
        logic [CFG_DATA_W-1:0] phase_ways   [NUM_PHASES];
        int                    phase_idle   [NUM_PHASES];
        logic [63:0]           rnd;
        int                    ob;
        int                    ib;
        int                    nw;

        phase_offset = '{4'd0, 4'd6, 4'd15, 4'd2, 4'd5, 4'd1, 4'd11, 4'd0};
        phase_index  = '{4'd0, 4'd6, 4'd15, 4'd3, 4'd1, 4'd2, 4'd14, 4'd4};
        phase_ways   = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd9, 4'd3, 4'd8, 4'd2};
        phase_idle   = '{0, 80, 0, 21, 80, 0, 21, 80};

        stall_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        address      = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 8-byte lines, 64 sets, 8 ways; tag starts at bit 9
        send_lookup('0, 0);
        send_lookup('0, 0);
        send_lookup({ADDR_BITS{1'b1}}, 0);
        send_lookup(48'hAAAA_AAAA_AAAA, 0);
        send_lookup(48'h5555_5555_5555, 0);
        for (int t = 1; t <= 9; t++)
            send_lookup(ADDR_BITS'(t) << 9, 0);
        send_lookup(ADDR_BITS'(2) << 9, 0);
        send_lookup(ADDR_BITS'(0), 0);
        send_lookup((ADDR_BITS'(5) << 9) | ADDR_BITS'(7), 0);
        send_lookup((ADDR_BITS'(3) << 9) | (ADDR_BITS'(63) << 3), 0);
        send_lookup(48'h8000_0000_0000, 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_lookups();
            write_reg(CFG_OFFSET_BITS, phase_offset[p]);
            write_reg(CFG_INDEX_BITS, phase_index[p]);
            write_reg(CFG_WAYS_IN_USE, phase_ways[p]);
            @(negedge clk);
            cfg_write <= 1'b0;

            ob = (phase_offset[p][2:0] > FIELD_LIMIT) ? int'(FIELD_LIMIT)
                                                      : int'(phase_offset[p][2:0]);
            ib = (phase_index[p][2:0] > FIELD_LIMIT) ? int'(FIELD_LIMIT)
                                                     : int'(phase_index[p][2:0]);
            if (phase_ways[p] == 0)
                nw = 1;
            else if (phase_ways[p] > MAX_WAYS)
                nw = MAX_WAYS;
            else
                nw = int'(phase_ways[p]);
            for (int i = 0; i < 12; i++)
            begin
                rnd = {$urandom(), $urandom()};
                tag_pool[i] = (i < 10) ? ADDR_BITS'(i) : rnd[ADDR_BITS-1:0];
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_lookup(stream_address(ob, ib, nw), phase_idle[p]);
        end

        drain_lookups();
        repeat (8) @(posedge clk);
        $display("Covered %0d lookups over %0d register settings, directed then random.",
                 lookups, NUM_PHASES + 1);
        $display("Of those, %0d hit and %0d evicted a valid line.", hits, evictions);
        if (errors == 0 && pending == 0)
            $display("set_associative_lru_lookup_top_tb: done, clean");
        else
            $display("set_associative_lru_lookup_top_tb: done, errors");
        $finish;
    end

endmodule
